FILE: rtl/clc_pkg.sv
package clc_pkg;

    // Byte codes that steer the canonicaliser.
    localparam logic [7:0] BYTE_NUL       = 8'd0;
    localparam logic [7:0] BYTE_TAB       = 8'd9;
    localparam logic [7:0] BYTE_NEWLINE   = 8'd10;
    localparam logic [7:0] BYTE_SPACE     = 8'd32;
    localparam logic [7:0] BYTE_HASH      = 8'd35;
    localparam logic [7:0] BYTE_COMMA     = 8'd44;
    localparam logic [7:0] BYTE_UPPER_A   = 8'd65;
    localparam logic [7:0] BYTE_UPPER_Z   = 8'd90;
    localparam logic [7:0] BYTE_BACKSLASH = 8'd92;
    localparam logic [7:0] CASE_OFFSET    = 8'd32;

    // Most result items that one input item can cause.
    localparam int MAX_RESULTS = 3;

    typedef logic [1:0] res_count_t;
    typedef logic [7:0] byte_t;

    // Only 'A' to 'Z' change; all other bytes pass unchanged.
    function automatic byte_t lower_byte(input byte_t b);
        if (b >= BYTE_UPPER_A && b <= BYTE_UPPER_Z) begin
            return b + CASE_OFFSET;
        end
        return b;
    endfunction

endpackage

FILE: rtl/config_line_canonicalizer_unit.sv
// Channel   Ports                               Direction  Handshake
// input     s_in_byte                           in         s_valid / s_ready
// result    m_out_byte, m_line_done             out        m_valid / m_ready
//
// Each input byte is decoded in the cycle that it is accepted; its results are
// available from the result buffer in the following cycle.
// Ordinary bytes give at most one result, so one item is taken in every cycle
// while m_ready holds. A newline can give up to three results; the next item
// waits until only the last of them remains in the buffer and is being taken.
// Reset (aresetn low, synchronous) empties the buffer and clears the line state.
module config_line_canonicalizer_unit
    import clc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_line_done
);

    // Line state.
    logic skip_rest_reg, skip_rest_next;
    logic escape_pending_reg, escape_pending_next;
    logic emitted_any_reg, emitted_any_next;
    logic last_was_zero_reg, last_was_zero_next;

    // Result buffer: slot 0 is presented on the result channel.
    res_count_t cnt_reg, cnt_next;
    byte_t      slot_byte_reg [MAX_RESULTS];
    byte_t      slot_byte_next [MAX_RESULTS];
    logic       slot_done_reg [MAX_RESULTS];
    logic       slot_done_next [MAX_RESULTS];

    // Decoded results of the incoming item.
    res_count_t res_cnt;
    byte_t      res_byte [MAX_RESULTS];
    logic       res_done [MAX_RESULTS];

    logic push;
    logic pop;

    assign m_valid     = (cnt_reg != res_count_t'(0));
    assign m_out_byte  = slot_byte_reg[0];
    assign m_line_done = slot_done_reg[0];
    assign s_ready     = (cnt_reg == res_count_t'(0)) ||
                         ((cnt_reg == res_count_t'(1)) && m_ready);
    assign push        = s_valid && s_ready;
    assign pop         = m_valid && m_ready;

    // Decode one byte into its results and the new line state.
    always_comb begin
        logic       bs_put;
        logic       eff_emitted;
        logic       eff_zero;
        res_count_t idx;
        res_cnt             = res_count_t'(0);
        idx                 = res_count_t'(0);
        bs_put              = 1'b0;
        eff_emitted         = 1'b0;
        eff_zero            = 1'b0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res_byte[i] = BYTE_NUL;
            res_done[i] = 1'b0;
        end
        skip_rest_next      = skip_rest_reg;
        escape_pending_next = escape_pending_reg;
        emitted_any_next    = emitted_any_reg;
        last_was_zero_next  = last_was_zero_reg;

        if (s_in_byte == BYTE_NEWLINE) begin
            // A pending backslash is kept as a plain byte, then the line closes.
            bs_put      = escape_pending_reg && !skip_rest_reg;
            eff_emitted = emitted_any_reg || bs_put;
            eff_zero    = last_was_zero_reg && !bs_put;
            if (bs_put) begin
                res_byte[idx] = BYTE_BACKSLASH;
                idx           = idx + res_count_t'(1);
            end
            if (eff_emitted) begin
                if (!eff_zero) begin
                    res_byte[idx] = BYTE_NUL;
                    idx           = idx + res_count_t'(1);
                end
                res_byte[idx] = BYTE_NUL;
                res_done[idx] = 1'b1;
                idx           = idx + res_count_t'(1);
            end
            res_cnt             = idx;
            skip_rest_next      = 1'b0;
            escape_pending_next = 1'b0;
            emitted_any_next    = 1'b0;
            last_was_zero_next  = 1'b0;
        end else if (skip_rest_reg) begin
            // Rest of the line is dropped.
        end else if (escape_pending_reg) begin
            escape_pending_next = 1'b0;
            res_cnt             = res_count_t'(1);
            emitted_any_next    = 1'b1;
            last_was_zero_next  = 1'b0;
            if (s_in_byte == BYTE_NUL) begin
                res_byte[0]    = BYTE_BACKSLASH;
                skip_rest_next = 1'b1;
            end else begin
                res_byte[0] = lower_byte(s_in_byte);
            end
        end else if (s_in_byte == BYTE_BACKSLASH) begin
            escape_pending_next = 1'b1;
        end else if (s_in_byte == BYTE_HASH || s_in_byte == BYTE_NUL) begin
            skip_rest_next = 1'b1;
        end else if (s_in_byte == BYTE_SPACE || s_in_byte == BYTE_TAB ||
                     s_in_byte == BYTE_COMMA) begin
            // A separator closes a token only once.
            if (emitted_any_reg && !last_was_zero_reg) begin
                res_cnt            = res_count_t'(1);
                res_byte[0]        = BYTE_NUL;
                last_was_zero_next = 1'b1;
            end
        end else begin
            res_cnt            = res_count_t'(1);
            res_byte[0]        = lower_byte(s_in_byte);
            emitted_any_next   = 1'b1;
            last_was_zero_next = 1'b0;
        end
    end

    // Buffer update: load new results, or shift out the one taken.
    always_comb begin
        cnt_next = cnt_reg;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_byte_next[i] = slot_byte_reg[i];
            slot_done_next[i] = slot_done_reg[i];
        end
        if (push) begin
            cnt_next = res_cnt;
            for (int i = 0; i < MAX_RESULTS; i++) begin
                slot_byte_next[i] = res_byte[i];
                slot_done_next[i] = res_done[i];
            end
        end else if (pop) begin
            cnt_next = cnt_reg - res_count_t'(1);
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                slot_byte_next[i] = slot_byte_reg[i + 1];
                slot_done_next[i] = slot_done_reg[i + 1];
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg            <= res_count_t'(0);
            skip_rest_reg      <= 1'b0;
            escape_pending_reg <= 1'b0;
            emitted_any_reg    <= 1'b0;
            last_was_zero_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                skip_rest_reg      <= skip_rest_next;
                escape_pending_reg <= escape_pending_next;
                emitted_any_reg    <= emitted_any_next;
                last_was_zero_reg  <= last_was_zero_next;
            end
        end
    end

    // Payload registers of the result buffer.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_byte_reg[i] <= slot_byte_next[i];
            slot_done_reg[i] <= slot_done_next[i];
        end
    end

    // The closing item of a line is always a zero byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_line_done) |-> (m_out_byte == BYTE_NUL))
        else $error("line_done on a non-zero byte");

    // A zero can only be the last byte if something was produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        last_was_zero_reg |-> emitted_any_reg)
        else $error("last_was_zero set on an empty line");

    // Dropping and escaping never overlap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(skip_rest_reg && escape_pending_reg))
        else $error("skip and escape both set");

    // A newline clears all line state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_in_byte == BYTE_NEWLINE) |=>
        (!skip_rest_reg && !escape_pending_reg && !emitted_any_reg))
        else $error("line state not cleared at newline");

    // The buffer never holds more than a newline can produce.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (cnt_reg <= res_count_t'(MAX_RESULTS)))
        else $error("result buffer overfilled");

endmodule

FILE: dv/testbench.sv
module testbench;
    import clc_pkg::*;

    localparam int QUIET_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 10;

    // One canonical output byte as the result channel should carry it.
    typedef struct packed {
        byte_t data;
        logic  done;
    } canon_byte_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_line_done;

    // Bytes still owed by the block, oldest first.
    canon_byte_t canon_queue[$];

    // Line state of the predictor.
    bit dropping_line;
    bit escape_seen;
    bit line_has_output;
    bit last_out_nul;

    bit sender_gaps;
    bit receiver_gaps;
    bit hold_off_request;
    int hold_off_left;
    int error_count;
    int items_sent;
    int quiet_cycles;

    config_line_canonicalizer_unit DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_line_done (m_line_done)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Only the capital letters move to lower case.
    function automatic byte_t fold_case(input byte_t b);
        if (b >= BYTE_UPPER_A && b <= BYTE_UPPER_Z) begin
            return byte_t'(b + CASE_OFFSET);
        end
        return b;
    endfunction

    function automatic void owe_byte(input byte_t b, input logic done);
        canon_byte_t entry;
        entry.data = b;
        entry.done = done;
        canon_queue.push_back(entry);
        line_has_output = 1'b1;
        last_out_nul    = (b == BYTE_NUL);
    endfunction

    // Works out the bytes that one accepted text byte gives.
    function automatic void canonicalise_byte(input byte_t b);
        if (b == BYTE_NEWLINE) begin
            if (escape_seen && !dropping_line) begin
                owe_byte(BYTE_BACKSLASH, 1'b0);
            end
            if (line_has_output) begin
                if (!last_out_nul) begin
                    owe_byte(BYTE_NUL, 1'b0);
                end
                owe_byte(BYTE_NUL, 1'b1);
            end
            dropping_line   = 1'b0;
            escape_seen     = 1'b0;
            line_has_output = 1'b0;
            last_out_nul    = 1'b0;
        end else if (!dropping_line) begin
            if (escape_seen) begin
                escape_seen = 1'b0;
                if (b == BYTE_NUL) begin
                    owe_byte(BYTE_BACKSLASH, 1'b0);
                    dropping_line = 1'b1;
                end else begin
                    owe_byte(fold_case(b), 1'b0);
                end
            end else if (b == BYTE_BACKSLASH) begin
                escape_seen = 1'b1;
            end else if (b == BYTE_HASH || b == BYTE_NUL) begin
                dropping_line = 1'b1;
            end else if (b == BYTE_SPACE || b == BYTE_TAB || b == BYTE_COMMA) begin
                if (line_has_output && !last_out_nul) begin
                    owe_byte(BYTE_NUL, 1'b0);
                end
            end else begin
                owe_byte(fold_case(b), 1'b0);
            end
        end
    endfunction

    // Offers one item, after a random pause when the sender idles, and waits for it to go.
    task automatic send_byte(input byte_t b);
        while (sender_gaps && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        canonicalise_byte(b);
        items_sent++;
    endtask

    // Mostly text-like bytes, with separators, escapes, comments and zeros mixed in.
    function automatic byte_t random_text_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) return byte_t'(BYTE_UPPER_A + $urandom_range(0, 25));
        if (pick < 50) return byte_t'(BYTE_UPPER_A + CASE_OFFSET + $urandom_range(0, 25));
        if (pick < 58) return BYTE_SPACE;
        if (pick < 62) return BYTE_TAB;
        if (pick < 66) return BYTE_COMMA;
        if (pick < 73) return BYTE_BACKSLASH;
        if (pick < 77) return BYTE_HASH;
        if (pick < 80) return BYTE_NUL;
        if (pick < 90) return byte_t'($urandom_range(0, 255));
        return byte_t'($urandom_range(33, 126));
    endfunction

    task automatic send_random_line();
        int len;
        len = $urandom_range(0, 14);
        repeat (len) send_byte(random_text_byte());
        send_byte(BYTE_NEWLINE);
    endtask

    task automatic send_random_lines(input int n_items);
        int start;
        start = items_sent;
        while (items_sent - start < n_items) begin
            send_random_line();
        end
    endtask

    // Hand-picked lines covering the corner cases of the line syntax.
    task automatic test_directed_lines();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        // An empty line gives nothing.
        send_byte(BYTE_NEWLINE);
        // Leading comma, case boundaries, an escaped space, a tab, a high byte and a
        // backslash just before the line end.
        send_byte(BYTE_COMMA);
        send_byte("A");
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_SPACE);
        send_byte("Z");
        send_byte(BYTE_TAB);
        send_byte("@");
        send_byte("[");
        send_byte(8'hFF);
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_NEWLINE);
        // Escaped hash and backslash, then a backslash before a zero byte; the
        // backslash after it falls in the dropped part.
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_HASH);
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_NUL);
        send_byte(BYTE_BACKSLASH);
        send_byte(BYTE_NEWLINE);
        // A token, a separator, then a comment: only the closing zero is added.
        send_byte(8'h7F);
        send_byte(BYTE_SPACE);
        send_byte(BYTE_HASH);
        send_byte(8'h80);
        send_byte(BYTE_NEWLINE);
        // A zero byte on a line that has produced nothing.
        send_byte(BYTE_NUL);
        send_byte(BYTE_NEWLINE);
    endtask

    task automatic test_random_lines();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        send_random_lines(190);
    endtask

    // Both sides run flat out for a while.
    task automatic test_back_to_back();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        send_random_lines(60);
    endtask

    // The receiver stops for a long time while the sender keeps offering items.
    task automatic test_receiver_hold_off();
        sender_gaps      = 1'b0;
        receiver_gaps    = 1'b1;
        hold_off_request = 1'b1;
        send_random_lines(40);
    endtask

    // Arbitrary bytes with an occasional newline.
    task automatic test_byte_noise();
        int start;
        start         = items_sent;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        while (items_sent - start < 60) begin
            if ($urandom_range(0, 99) < 10) begin
                send_byte(BYTE_NEWLINE);
            end else begin
                send_byte(byte_t'($urandom_range(0, 255)));
            end
        end
        send_byte(BYTE_NEWLINE);
    endtask

    // Result side: check each accepted item, then choose the next ready.
    initial begin
        canon_byte_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (canon_queue.size() == 0) begin
                    $error("unexpected item: out_byte %0d line_done %0b",
                           m_out_byte, m_line_done);
                    error_count++;
                end else begin
                    want = canon_queue.pop_front();
                    if (m_out_byte !== want.data) begin
                        $error("out_byte: expected %0d, got %0d", want.data, m_out_byte);
                        error_count++;
                    end
                    if (m_line_done !== want.done) begin
                        $error("line_done: expected %0b, got %0b", want.done, m_line_done);
                        error_count++;
                    end
                end
            end
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_off_left    = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_ready <= 1'b0;
            end else if (receiver_gaps) begin
                m_ready <= ($urandom_range(0, 99) >= 29);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Ends the run if neither channel moves for too long.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_in_byte = 8'd0;
        m_ready   = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_lines();
        test_random_lines();
        test_back_to_back();
        test_receiver_hold_off();
        test_byte_noise();
        s_valid <= 1'b0;

        // Drain what is still owed, then let the block settle before the verdict.
        while (canon_queue.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/clc_pkg.sv
rtl/config_line_canonicalizer_unit.sv
dv/testbench.sv
